FILE: hdl/prs_pkg.sv
package prs_pkg;

  // Field widths fixed by the item formats
  localparam int LEN_FIELD_BITS = 16;
  localparam int RATE_BITS      = 48;
  localparam int MEAN_BITS      = 24;
  localparam int MEAN_FRAC_BITS = 8;
  localparam int MEAN_INT_BITS  = MEAN_BITS - MEAN_FRAC_BITS;
  localparam int SCALE_BITS     = 32;
  localparam int SCALE_FRAC_BITS = 16;

  // Reset value of the rate scale: 1.0 in Q16.16
  localparam logic [SCALE_BITS-1:0] RATE_SCALE_RESET = 32'h0001_0000;

  // Item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [LEN_FIELD_BITS-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [RATE_BITS-1:0]      packets_per_second;
    logic [RATE_BITS-1:0]      bytes_per_second;
    logic [LEN_FIELD_BITS-1:0] smallest_length;
    logic [MEAN_BITS-1:0]      mean_length;
    logic [LEN_FIELD_BITS-1:0] largest_length;
  } out_item_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } back_state_e;

endpackage

FILE: hdl/packet_rate_statistics.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_ready_o   | in_item_i   (prs_pkg::in_item_t)
// out      | output    | out_valid_o / out_ready_i | out_item_o  (prs_pkg::out_item_t)
// cfg      | input     | cfg_we_i                  | cfg_wdata_i (rate scale, Q16.16)
//
// An item is taken every cycle while the queue has room; a packet report only updates
// the accumulators, and a tick snapshots the interval into a two-entry queue.
// Per tick the back end takes the snapshot, forms the four products on one shared
// 32x32 multiplier, runs the bit-serial mean divider and publishes; the divider is
// skipped when the interval counted no packets or the mean saturates.
// The input stalls only while the queue holds two intervals the back end has not
// started. Reset clears the accumulators and sets the rate scale to 1.0.
module packet_rate_statistics #(
  parameter int LENGTH_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  prs_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output prs_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [prs_pkg::SCALE_BITS-1:0] cfg_wdata_i
);

  localparam int BYTE_BITS   = (COUNT_BITS + LENGTH_BITS > 64) ? 64 : COUNT_BITS + LENGTH_BITS;
  localparam int SNAP_BITS   = COUNT_BITS + BYTE_BITS + 2 * prs_pkg::LEN_FIELD_BITS;
  localparam int QUEUE_DEPTH = 2;

  logic [prs_pkg::SCALE_BITS-1:0] rate_scale_q;
  logic                           q_push;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_empty;
  logic [SNAP_BITS-1:0]           q_wdata;
  logic [SNAP_BITS-1:0]           q_rdata;

  // Hold the rate scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q <= prs_pkg::RATE_SCALE_RESET;
    end else if (cfg_we_i) begin
      rate_scale_q <= cfg_wdata_i;
    end
  end

  prs_front #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  prs_queue #(
    .WIDTH (SNAP_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  prs_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (rate_scale_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // No snapshot is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("interval pushed into full queue");

  // No snapshot is popped from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("interval popped from empty queue");

  // A nonzero mean needs a nonzero largest length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.mean_length != '0) |-> (out_item_o.largest_length != '0))
    else $error("nonzero mean with zero largest length");

  // A set smallest length never exceeds the largest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.smallest_length != '0) |->
      (out_item_o.smallest_length <= out_item_o.largest_length))
    else $error("smallest length above largest length");

endmodule

FILE: hdl/prs_front.sv
module prs_front #(
  parameter int LENGTH_BITS = 16,
  parameter int COUNT_BITS  = 32,
  localparam int BYTE_BITS  = (COUNT_BITS + LENGTH_BITS > 64) ? 64 : COUNT_BITS + LENGTH_BITS,
  localparam int SNAP_BITS  = COUNT_BITS + BYTE_BITS + 2 * prs_pkg::LEN_FIELD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prs_pkg::in_item_t     in_item_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [SNAP_BITS-1:0]  q_data_o
);

  localparam int LEN_USED = (LENGTH_BITS > prs_pkg::LEN_FIELD_BITS) ?
                            prs_pkg::LEN_FIELD_BITS : LENGTH_BITS;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [BYTE_BITS-1:0]  bytes_q, bytes_d;
  logic [LEN_USED-1:0]   floor_q, floor_d;
  logic [LEN_USED-1:0]   ceil_q, ceil_d;
  logic [LEN_USED-1:0]   len;
  logic [BYTE_BITS:0]    byte_sum;
  logic                  accept;
  logic                  is_tick;

  // Packets never need queue space, but keep ready independent of the payload
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (in_item_i.kind == prs_pkg::KIND_TICK);
  assign len        = in_item_i.packet_length[LEN_USED-1:0];
  assign byte_sum   = {1'b0, bytes_q} + (BYTE_BITS + 1)'(len);

  // Hand the finished interval to the back end on a tick
  assign q_push_o = accept && is_tick;
  assign q_data_o = {count_q, bytes_q,
                     prs_pkg::LEN_FIELD_BITS'(floor_q),
                     prs_pkg::LEN_FIELD_BITS'(ceil_q)};

  // Accumulate on a packet, clear on a tick
  always_comb begin
    count_d = count_q;
    bytes_d = bytes_q;
    floor_d = floor_q;
    ceil_d  = ceil_q;
    if (accept && is_tick) begin
      count_d = '0;
      bytes_d = '0;
      floor_d = '0;
      ceil_d  = '0;
    end else if (accept) begin
      if (!(&count_q)) begin
        count_d = count_q + COUNT_BITS'(1);
      end
      // saturate the byte count on carry out
      bytes_d = byte_sum[BYTE_BITS] ? '1 : byte_sum[BYTE_BITS-1:0];
      // zero floor means unset
      if (len < floor_q || floor_q == '0) begin
        floor_d = len;
      end
      if (len > ceil_q) begin
        ceil_d = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bytes_q <= '0;
      floor_q <= '0;
      ceil_q  <= '0;
    end else begin
      count_q <= count_d;
      bytes_q <= bytes_d;
      floor_q <= floor_d;
      ceil_q  <= ceil_d;
    end
  end

endmodule

FILE: hdl/prs_queue.sv
module prs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/prs_back.sv
module prs_back #(
  parameter int LENGTH_BITS = 16,
  parameter int COUNT_BITS  = 32,
  localparam int BYTE_BITS  = (COUNT_BITS + LENGTH_BITS > 64) ? 64 : COUNT_BITS + LENGTH_BITS,
  localparam int SNAP_BITS  = COUNT_BITS + BYTE_BITS + 2 * prs_pkg::LEN_FIELD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [prs_pkg::SCALE_BITS-1:0]     scale_i,
  input  logic                               q_empty_i,
  output logic                               q_pop_o,
  input  logic [SNAP_BITS-1:0]               q_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output prs_pkg::out_item_t                 out_item_o
);

  localparam int LF        = prs_pkg::LEN_FIELD_BITS;
  localparam int RB        = prs_pkg::RATE_BITS;
  localparam int MB        = prs_pkg::MEAN_BITS;
  localparam int SB        = prs_pkg::SCALE_BITS;
  localparam int PB        = 2 * SB;
  localparam int MUL_STEPS = 4;
  localparam int STEP_BITS = $clog2(MUL_STEPS + 1);
  localparam int BIT_BITS  = $clog2(MB);
  localparam int CMP_BITS  = (BYTE_BITS > COUNT_BITS + prs_pkg::MEAN_INT_BITS) ?
                             BYTE_BITS : COUNT_BITS + prs_pkg::MEAN_INT_BITS;

  prs_pkg::back_state_e state_q, state_d;

  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [BIT_BITS-1:0]   bit_q, bit_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [BYTE_BITS-1:0]  byt_q, byt_d;
  logic [LF-1:0]         floor_q, floor_d;
  logic [LF-1:0]         ceil_q, ceil_d;
  logic [PB-1:0]         prod_q, prod_d;
  logic [RB-1:0]         lo_q, lo_d;
  logic [RB-1:0]         pps_q, pps_d;
  logic [RB-1:0]         bps_q, bps_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [MB-1:0]         sh_q, sh_d;
  logic [MB-1:0]         quo_q, quo_d;
  prs_pkg::out_item_t    out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [63:0]           cnt64;
  logic [63:0]           byt64;
  logic [SB-1:0]         mul_op;
  logic [RB:0]           rate_sum;
  logic [RB-1:0]         rate_val;
  logic [COUNT_BITS:0]   rem_shift;
  logic                  rem_ge;
  logic                  mean_ovf;

  assign cnt64 = 64'(cnt_q);
  assign byt64 = 64'(byt_q);

  // Pick the 32-bit half for the shared multiplier
  always_comb begin
    case (step_q[1:0])
      2'd0:    mul_op = cnt64[SB-1:0];
      2'd1:    mul_op = cnt64[PB-1:SB];
      2'd2:    mul_op = byt64[SB-1:0];
      default: mul_op = byt64[PB-1:SB];
    endcase
  end

  // Combine high product with the stored low part, saturate at 48 bits
  assign rate_sum = {1'b0, prod_q[SB-1:0], prs_pkg::SCALE_FRAC_BITS'(0)} + {1'b0, lo_q};
  assign rate_val = (prod_q[PB-1:SB] != '0 || rate_sum[RB]) ? '1 : rate_sum[RB-1:0];

  // One restoring division step; remainder stays below the divisor
  assign rem_shift = {rem_q, sh_q[MB-1]};
  assign rem_ge    = (rem_shift >= {1'b0, cnt_q});

  // Mean overflows Q16.8 when bytes >= packets * 2^16
  assign mean_ovf = (CMP_BITS'(byt_q) >= (CMP_BITS'(cnt_q) << prs_pkg::MEAN_INT_BITS));

  // Sequence one interval: load, four products, divide (skipped on zero count or overflow), publish
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    byt_d       = byt_q;
    floor_d     = floor_q;
    ceil_d      = ceil_q;
    prod_d      = prod_q;
    lo_d        = lo_q;
    pps_d       = pps_q;
    bps_d       = bps_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    quo_d       = quo_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      prs_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          {cnt_d, byt_d, floor_d, ceil_d} = q_data_i;
          step_d  = '0;
          state_d = prs_pkg::ST_MUL;
        end
      end
      prs_pkg::ST_MUL: begin
        if (step_q < STEP_BITS'(MUL_STEPS)) begin
          prod_d = 64'(mul_op) * 64'(scale_i);
        end
        if (step_q != '0) begin
          if (step_q[0]) begin
            lo_d = prod_q[PB-1:prs_pkg::SCALE_FRAC_BITS];
          end else if (step_q == STEP_BITS'(2)) begin
            pps_d = rate_val;
          end else begin
            bps_d = rate_val;
          end
        end
        step_d = step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(MUL_STEPS)) begin
          bit_d = '0;
          quo_d = '0;
          rem_d = COUNT_BITS'(byt_q >> prs_pkg::MEAN_INT_BITS);
          sh_d  = {byt_q[prs_pkg::MEAN_INT_BITS-1:0], prs_pkg::MEAN_FRAC_BITS'(0)};
          if (cnt_q == '0) begin
            state_d = prs_pkg::ST_LOAD;
          end else if (mean_ovf) begin
            quo_d   = '1;
            state_d = prs_pkg::ST_LOAD;
          end else begin
            state_d = prs_pkg::ST_DIV;
          end
        end
      end
      prs_pkg::ST_DIV: begin
        quo_d = {quo_q[MB-2:0], rem_ge};
        rem_d = rem_ge ? COUNT_BITS'(rem_shift - {1'b0, cnt_q}) : COUNT_BITS'(rem_shift);
        sh_d  = sh_q << 1;
        bit_d = bit_q + BIT_BITS'(1);
        if (bit_q == BIT_BITS'(MB - 1)) begin
          state_d = prs_pkg::ST_LOAD;
        end
      end
      prs_pkg::ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.packets_per_second = pps_q;
          out_d.bytes_per_second   = bps_q;
          out_d.smallest_length    = floor_q;
          out_d.mean_length        = quo_q;
          out_d.largest_length     = ceil_q;
          out_valid_d              = 1'b1;
          state_d                  = prs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prs_pkg::ST_IDLE;
      step_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    byt_q   <= byt_d;
    floor_q <= floor_d;
    ceil_q  <= ceil_d;
    prod_q  <= prod_d;
    lo_q    <= lo_d;
    pps_q   <= pps_d;
    bps_q   <= bps_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    quo_q   <= quo_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
